[src/gpu_command_puller_core_macros.svh]
// Assertion helpers shared by the command puller modules.
// Each expects clk and arst_n in the scope of the module that uses it.
`ifndef GPU_COMMAND_PULLER_CORE_MACROS_SVH
`define GPU_COMMAND_PULLER_CORE_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define GCP_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed in %m");

// Consequent holds in the cycle after the antecedent.
`define GCP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed in %m");

`endif

[src/gcp_pkg.sv]
`timescale 1ns / 1ps
package gcp_pkg;

	localparam int NUM_SUBCHANNELS = 8;

	localparam int METHOD_W  = 13;
	localparam int SUBCH_W   = 3;
	localparam int WORD_W    = 32;
	localparam int TICK_W    = 64;
	localparam int ADDR_HI_W = 8;
	localparam int ADDR_W    = ADDR_HI_W + WORD_W;
	localparam int ACTION_W  = 3;
	localparam int SUBCH_SLOTS = 2 ** SUBCH_W;

	localparam logic [ACTION_W-1:0] ACT_NONE       = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_FORWARD    = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_WRITE_LONG = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_WRITE_WORD = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_UNIMPL     = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_BAD_SEM    = 3'd5;

	localparam logic [METHOD_W-1:0] MTH_BIND      = 13'h000;
	localparam logic [METHOD_W-1:0] MTH_NOP       = 13'h002;
	localparam logic [METHOD_W-1:0] MTH_SEM_HI    = 13'h004;
	localparam logic [METHOD_W-1:0] MTH_SEM_LO    = 13'h005;
	localparam logic [METHOD_W-1:0] MTH_SEM_SEQ   = 13'h006;
	localparam logic [METHOD_W-1:0] MTH_TRIGGER   = 13'h007;
	localparam logic [METHOD_W-1:0] MTH_NOP_ALT   = 13'h014;
	localparam logic [METHOD_W-1:0] MTH_ACQUIRE   = 13'h01A;
	localparam logic [METHOD_W-1:0] MTH_RELEASE   = 13'h01B;
	localparam logic [METHOD_W-1:0] MTH_FIRST_FWD = 13'h040;

	localparam int SEM_OP_W = 4;
	localparam logic [SEM_OP_W-1:0] OP_ACQ_EQ     = 4'h1;
	localparam logic [SEM_OP_W-1:0] OP_WRITE_LONG = 4'h2;
	localparam logic [SEM_OP_W-1:0] OP_ACQ_GT     = 4'h4;
	localparam logic [SEM_OP_W-1:0] OP_ACQ_MASK   = 4'h8;

	localparam int KIND_W = 4;
	localparam logic [KIND_W-1:0] KIND_FORWARD = 4'd0;
	localparam logic [KIND_W-1:0] KIND_BIND    = 4'd1;
	localparam logic [KIND_W-1:0] KIND_NOP     = 4'd2;
	localparam logic [KIND_W-1:0] KIND_SEM_HI  = 4'd3;
	localparam logic [KIND_W-1:0] KIND_SEM_LO  = 4'd4;
	localparam logic [KIND_W-1:0] KIND_SEM_SEQ = 4'd5;
	localparam logic [KIND_W-1:0] KIND_TRIGGER = 4'd6;
	localparam logic [KIND_W-1:0] KIND_ACQUIRE = 4'd7;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 4'd8;
	localparam logic [KIND_W-1:0] KIND_UNIMPL  = 4'd9;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [METHOD_W-1:0] method;
		logic [SUBCH_W-1:0]  subchannel;
		logic [WORD_W-1:0]   argument;
		logic [WORD_W-1:0]   mem_word;
		logic [TICK_W-1:0]   tick_count;
	} cmd_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [WORD_W-1:0]   engine_id;
		logic [METHOD_W-1:0] method_out;
		logic [WORD_W-1:0]   argument_out;
		logic [ADDR_W-1:0]   mem_address;
		logic [WORD_W-1:0]   write_value;
		logic [TICK_W-1:0]   write_timestamp;
		logic                wait_active;
		logic                wait_mode;
		logic                wait_source;
		logic [WORD_W-1:0]   wait_value;
	} res_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              sub_ok;
		cmd_t              cmd;
	} entry_t;

	typedef struct packed {
		logic full;
		logic head_valid;
	} q_status_t;

endpackage

[src/gcp_front.sv]
`timescale 1ns / 1ps
module gcp_front (
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  gcp_pkg::cmd_t    cmd,
	input  gcp_pkg::q_status_t q_status,
	output logic             push,
	output gcp_pkg::entry_t  entry
);
	import gcp_pkg::*;

	assign cmd_stall = q_status.full;
	assign push      = cmd_valid && !q_status.full;

	always_comb begin
		entry.cmd    = cmd;
		entry.sub_ok = 32'(cmd.subchannel) < 32'(NUM_SUBCHANNELS);
		if (cmd.method >= MTH_FIRST_FWD) begin
			entry.kind = KIND_FORWARD;
		end else begin
			unique case (cmd.method) inside
				MTH_BIND:             entry.kind = KIND_BIND;
				MTH_NOP, MTH_NOP_ALT: entry.kind = KIND_NOP;
				MTH_SEM_HI:           entry.kind = KIND_SEM_HI;
				MTH_SEM_LO:           entry.kind = KIND_SEM_LO;
				MTH_SEM_SEQ:          entry.kind = KIND_SEM_SEQ;
				MTH_TRIGGER:          entry.kind = KIND_TRIGGER;
				MTH_ACQUIRE:          entry.kind = KIND_ACQUIRE;
				MTH_RELEASE:          entry.kind = KIND_RELEASE;
				default:              entry.kind = KIND_UNIMPL;
			endcase
		end
	end

endmodule

[src/gcp_queue.sv]
`timescale 1ns / 1ps
`include "gpu_command_puller_core_macros.svh"
module gcp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  gcp_pkg::entry_t    push_entry,
	input  logic               pop,
	output gcp_pkg::entry_t    head,
	output gcp_pkg::q_status_t q_status
);
	import gcp_pkg::*;

	entry_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head                = slot_q[rd_ptr_q];
	assign q_status.full       = count_q == QCNT_W'(QUEUE_DEPTH);
	assign q_status.head_valid = count_q != '0;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`GCP_ASSERT_SAME(a_no_push_when_full, count_q == QCNT_W'(QUEUE_DEPTH), !push)
	`GCP_ASSERT_SAME(a_no_pop_when_empty, count_q == '0, !pop)
	`GCP_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1)
	`GCP_ASSERT_NEXT(a_count_down, pop && !push, count_q == $past(count_q) - 1'b1)

endmodule

[src/gcp_back.sv]
`timescale 1ns / 1ps
`include "gpu_command_puller_core_macros.svh"
module gcp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  gcp_pkg::entry_t head,
	output logic            pop,
	output logic            res_valid,
	input  logic            res_stall,
	output gcp_pkg::res_t   res
);
	import gcp_pkg::*;

	logic [WORD_W-1:0]    bound_q [SUBCH_SLOTS];
	logic [ADDR_HI_W-1:0] sem_hi_q;
	logic [WORD_W-1:0]    sem_lo_q;
	logic [WORD_W-1:0]    sem_seq_q;
	logic                 wait_active_q;
	logic                 wait_mode_q;
	logic                 wait_source_q;
	logic [WORD_W-1:0]    wait_value_q;
	logic                 res_valid_q;
	res_t                 res_q;

	res_t                 nxt;
	logic [SEM_OP_W-1:0]  op;
	logic [WORD_W-1:0]    diff;
	logic                 trig_ok;
	logic [ADDR_W-1:0]    sem_addr;

	assign pop       = head_valid && (!res_valid_q || !res_stall);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign op       = head.cmd.argument[SEM_OP_W-1:0];
	assign diff     = head.cmd.mem_word - sem_seq_q;
	assign sem_addr = {sem_hi_q, sem_lo_q};
	assign trig_ok  = (op == OP_ACQ_EQ && head.cmd.mem_word == sem_seq_q)
		|| (op == OP_ACQ_GT && diff != '0 && !diff[WORD_W-1])
		|| (op == OP_ACQ_MASK && (head.cmd.mem_word & sem_seq_q) != '0);

	always_comb begin
		nxt             = '0;
		nxt.action      = ACT_NONE;
		nxt.wait_active = wait_active_q;
		nxt.wait_mode   = wait_mode_q;
		nxt.wait_source = wait_source_q;
		nxt.wait_value  = wait_value_q;
		unique case (head.kind)
			KIND_FORWARD: begin
				nxt.action       = ACT_FORWARD;
				nxt.engine_id    = head.sub_ok ? bound_q[head.cmd.subchannel] : '0;
				nxt.method_out   = head.cmd.method;
				nxt.argument_out = head.cmd.argument;
			end
			KIND_TRIGGER: begin
				if (op == OP_WRITE_LONG) begin
					nxt.action          = ACT_WRITE_LONG;
					nxt.mem_address     = sem_addr;
					nxt.write_value     = sem_seq_q;
					nxt.write_timestamp = head.cmd.tick_count;
				end else if (!trig_ok) begin
					// failed check: arm the wait, mask and unknown ops report instead
					nxt.wait_source = 1'b1;
					nxt.wait_value  = sem_seq_q;
					if (op == OP_ACQ_EQ) begin
						nxt.wait_active = 1'b1;
						nxt.wait_mode   = 1'b0;
					end else if (op == OP_ACQ_GT) begin
						nxt.wait_active = 1'b1;
						nxt.wait_mode   = 1'b1;
					end else begin
						nxt.action = ACT_BAD_SEM;
					end
				end
			end
			KIND_ACQUIRE: begin
				if (head.cmd.mem_word != head.cmd.argument) begin
					nxt.wait_active = 1'b1;
					nxt.wait_mode   = 1'b0;
					nxt.wait_source = 1'b0;
					nxt.wait_value  = head.cmd.argument;
				end
			end
			KIND_RELEASE: begin
				nxt.action      = ACT_WRITE_WORD;
				nxt.mem_address = sem_addr;
				nxt.write_value = head.cmd.argument;
			end
			KIND_UNIMPL: nxt.action = ACT_UNIMPL;
			default:     nxt.action = ACT_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SUBCH_SLOTS; i++) begin
				bound_q[i] <= '0;
			end
			sem_hi_q      <= '0;
			sem_lo_q      <= '0;
			sem_seq_q     <= '0;
			wait_active_q <= 1'b0;
			wait_mode_q   <= 1'b0;
			wait_source_q <= 1'b0;
			wait_value_q  <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			res_valid_q <= pop || (res_valid_q && res_stall);
			if (pop) begin
				wait_active_q <= nxt.wait_active;
				wait_mode_q   <= nxt.wait_mode;
				wait_source_q <= nxt.wait_source;
				wait_value_q  <= nxt.wait_value;
				if (head.kind == KIND_BIND && head.sub_ok) begin
					bound_q[head.cmd.subchannel] <= head.cmd.argument;
				end
				if (head.kind == KIND_SEM_HI) begin
					sem_hi_q <= head.cmd.argument[ADDR_HI_W-1:0];
				end
				if (head.kind == KIND_SEM_LO) begin
					sem_lo_q <= head.cmd.argument;
				end
				if (head.kind == KIND_SEM_SEQ) begin
					sem_seq_q <= head.cmd.argument;
				end
			end
		end
	end

	// hold the result while the consumer stalls
	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= nxt;
		end
	end

	`GCP_ASSERT_NEXT(a_wait_sticky, wait_active_q, wait_active_q)
	`GCP_ASSERT_NEXT(a_acquire_arms,
		pop && head.kind == KIND_ACQUIRE && head.cmd.mem_word != head.cmd.argument,
		wait_active_q && !wait_source_q && res_q.wait_active)
	`GCP_ASSERT_NEXT(a_bind_quiet, pop && head.kind == KIND_BIND,
		res_valid_q && res_q.action == ACT_NONE)

endmodule

[src/gpu_command_puller_core.sv]
`timescale 1ns / 1ps
// Command puller: takes one method call per item and returns exactly one
// result item for it. A front stage decodes the method into a command kind
// and pushes it into a two-entry queue; a back stage applies the kind to the
// subchannel bindings, semaphore registers and acquire-wait state, and loads
// the result into an output register. Sustained rate is one item per clock
// while the result side is not stalled. An accepted item is first written
// into the queue and is popped from it into the output register, which
// presents its result; the queue absorbs up to two items while the result
// side is stalled, one more being held in the output register. Methods from
// 0x40 up are forwarded with the engine id bound to their subchannel.
module gpu_command_puller_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  gcp_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output gcp_pkg::res_t res
);
	import gcp_pkg::*;

	q_status_t q_status;
	logic      push;
	logic      pop;
	entry_t    push_entry;
	entry_t    head;

	gcp_front u_front (
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.q_status  (q_status),
		.push      (push),
		.entry     (push_entry)
	);

	gcp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_status   (q_status)
	);

	gcp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_status.head_valid),
		.head       (head),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

endmodule
